>>> rtl/mst_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Prim spanning tree core.
// Used by mst_ctrl, mst_dp, the top level and the checker; depends on nothing.
package mst_pkg;

	localparam int MaxVertices = 16;
	localparam int IdxW        = $clog2(MaxVertices);
	localparam int CntW        = IdxW + 1;
	localparam int AddrW       = 2 * IdxW;
	localparam int EdgeDepth   = MaxVertices * MaxVertices;
	localparam int WeightW     = 31;
	localparam int DataW       = 32;

	localparam logic [WeightW-1:0] NoEdge = {WeightW{1'b1}};

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LABEL = 2'd1,
		OP_EDGE  = 2'd2,
		OP_RUN   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_EDGE         = 2'd0,
		ST_NOT_FOUND    = 2'd1,
		ST_SINGLE       = 2'd2,
		ST_DISCONNECTED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_EDGE_BA,
		S_FIND,
		S_NOT_FOUND,
		S_SINGLE,
		S_INIT,
		S_SELECT,
		S_EMIT,
		S_UPDATE
	} state_t;

	typedef struct packed {
		logic    capture;
		logic    clear;
		logic    lbl_wr;
		logic    ew_wr;
		logic    ew_swap;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    rd_en;
		logic    upd_mode;
		logic    k_load;
		logic    sel_step;
		logic    join_en;
		logic    out_ld;
		status_t out_status;
		logic    out_last;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    w_ok;
		logic    j_end;
		logic    lbl_match;
		logic    pick;
		logic    is_last;
		logic    single;
		logic    out_free;
	} sts_t;

endpackage

>>> rtl/prim_minimum_spanning_tree_core.sv
`timescale 1ns / 1ps
// Top level of the Prim spanning tree core: joins mst_ctrl and mst_dp.
// Depends on mst_pkg, mst_ctrl and mst_dp.
//
// The core keeps a graph of up to 16 vertices as an edge weight memory plus
// vertex labels and runs Prim's algorithm on it. One item is taken at a time.
// Clear and label load are done at dispatch; an accepted edge write makes two
// writes through the one write port of the edge memory. A run first scans the
// labels for the start label, then loads the costs from its row, and for each
// of up to n - 1 joins makes one pass over the cost array for the minimum and
// one pass over a row of the edge memory, one entry per cycle. A clear takes
// effect at once through per-entry valid bits, so no clearing pass follows
// reset. The finished result sits in an output register, so a new item can be
// taken while the last result beat still waits.
module prim_minimum_spanning_tree_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          opcode,
	input  logic [3:0]          index_a,
	input  logic [3:0]          index_b,
	input  logic signed [31:0]  value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [31:0]  from_label,
	output logic signed [31:0]  to_label,
	output logic                last
);

	mst_pkg::cmd_t    cmd;
	mst_pkg::sts_t    sts;
	mst_pkg::status_t o_status;

	assign cfg_ready = 1'b1;

	mst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mst_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_valid & cfg_ready),
		.cfg_data   (cfg_data),
		.in_opcode  (opcode),
		.in_index_a (index_a),
		.in_index_b (index_b),
		.in_value   (value),
		.out_stall  (out_stall),
		.o_valid    (out_valid),
		.o_status   (o_status),
		.o_from     (from_label),
		.o_to       (to_label),
		.o_last     (last)
	);

	assign status = o_status;

endmodule

>>> rtl/mst_dp.sv
`timescale 1ns / 1ps
// Datapath of the spanning tree core: edge weight memory, label and cost arrays,
// scan counter, minimum search and the output register. Depends on mst_pkg.
module mst_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mst_pkg::cmd_t                     cmd,
	output mst_pkg::sts_t                     sts,
	input  logic                              cfg_we,
	input  logic [mst_pkg::CntW-1:0]          cfg_data,
	input  logic [1:0]                        in_opcode,
	input  logic [mst_pkg::IdxW-1:0]          in_index_a,
	input  logic [mst_pkg::IdxW-1:0]          in_index_b,
	input  logic signed [mst_pkg::DataW-1:0]  in_value,
	input  logic                              out_stall,
	output logic                              o_valid,
	output mst_pkg::status_t                  o_status,
	output logic signed [mst_pkg::DataW-1:0]  o_from,
	output logic signed [mst_pkg::DataW-1:0]  o_to,
	output logic                              o_last
);

	logic [mst_pkg::CntW-1:0]    vc_q;
	logic [mst_pkg::CntW-1:0]    n_act;
	mst_pkg::opcode_t            op_q;
	logic [mst_pkg::IdxW-1:0]    a_q;
	logic [mst_pkg::IdxW-1:0]    b_q;
	logic [mst_pkg::DataW-1:0]   val_q;

	logic [mst_pkg::CntW-1:0]    j_q;
	logic [mst_pkg::IdxW-1:0]    k_q;
	logic [mst_pkg::IdxW-1:0]    sel_q;
	logic [mst_pkg::IdxW-1:0]    e_q;
	logic [mst_pkg::WeightW-1:0] best_q;
	logic                        pick_q;
	logic [mst_pkg::DataW-1:0]   klbl_q;

	logic [mst_pkg::WeightW-1:0] ew_mem [mst_pkg::EdgeDepth];
	logic [mst_pkg::EdgeDepth-1:0] ev_q;
	logic [mst_pkg::AddrW-1:0]   rd_addr;
	logic [mst_pkg::AddrW-1:0]   wr_addr;
	logic [mst_pkg::WeightW-1:0] ew_rd_s1;
	logic                        ev_rd_s1;
	logic                        rv_s1;
	logic [mst_pkg::IdxW-1:0]    j_s1;
	logic [mst_pkg::WeightW-1:0] weight_s1;

	logic [mst_pkg::WeightW-1:0] lc_q   [mst_pkg::MaxVertices];
	logic [mst_pkg::DataW-1:0]   nl_q   [mst_pkg::MaxVertices];
	logic [mst_pkg::DataW-1:0]   lbl_q  [mst_pkg::MaxVertices];
	logic [mst_pkg::IdxW-1:0]    lc_raddr;
	logic [mst_pkg::WeightW-1:0] lc_rd;
	logic [mst_pkg::IdxW-1:0]    lbl_raddr;
	logic [mst_pkg::DataW-1:0]   lbl_rd;
	logic                        relax;

	logic                        o_vld_q;
	mst_pkg::status_t            o_status_q;
	logic [mst_pkg::DataW-1:0]   o_from_q;
	logic [mst_pkg::DataW-1:0]   o_to_q;
	logic                        o_last_q;

	// A register value of zero acts as one vertex; values above MaxVertices saturate to it.
	always_comb begin
		if (vc_q == '0) begin
			n_act = mst_pkg::CntW'(1);
		end else if (vc_q > mst_pkg::CntW'(mst_pkg::MaxVertices)) begin
			n_act = mst_pkg::CntW'(mst_pkg::MaxVertices);
		end else begin
			n_act = vc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= mst_pkg::CntW'(mst_pkg::MaxVertices);
		end else if (cfg_we) begin
			vc_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= mst_pkg::opcode_t'(in_opcode);
			a_q   <= in_index_a;
			b_q   <= in_index_b;
			val_q <= in_value;
		end
	end

	// Edge memory: one write port, one registered read port.
	assign rd_addr = {k_q, j_q[mst_pkg::IdxW-1:0]};
	assign wr_addr = cmd.ew_swap ? {b_q, a_q} : {a_q, b_q};

	always_ff @(posedge clk) begin
		if (cmd.ew_wr) begin
			ew_mem[wr_addr] <= val_q[mst_pkg::WeightW-1:0];
		end
		ew_rd_s1 <= ew_mem[rd_addr];
		ev_rd_s1 <= ev_q[rd_addr];
		j_s1     <= j_q[mst_pkg::IdxW-1:0];
	end

	// An entry that was never written since the last clear reads as no edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= '0;
		end else if (cmd.clear) begin
			ev_q <= '0;
		end else if (cmd.ew_wr) begin
			ev_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= cmd.rd_en;
		end
	end

	assign weight_s1 = ev_rd_s1 ? ew_rd_s1 : mst_pkg::NoEdge;

	assign lc_raddr  = rv_s1 ? j_s1 : j_q[mst_pkg::IdxW-1:0];
	assign lc_rd     = lc_q[lc_raddr];
	assign lbl_raddr = cmd.join_en ? sel_q : j_q[mst_pkg::IdxW-1:0];
	assign lbl_rd    = lbl_q[lbl_raddr];
	assign relax     = weight_s1 < lc_rd;

	always_ff @(posedge clk) begin
		if (cmd.lbl_wr) begin
			lbl_q[a_q] <= val_q;
		end
		if (rv_s1) begin
			if (!cmd.upd_mode) begin
				lc_q[j_s1] <= (j_s1 == k_q) ? '0 : weight_s1;
				nl_q[j_s1] <= val_q;
			end else if (relax) begin
				lc_q[j_s1] <= weight_s1;
				nl_q[j_s1] <= klbl_q;
			end
		end else if (cmd.join_en) begin
			lc_q[sel_q] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q    <= '0;
			k_q    <= '0;
			e_q    <= '0;
			sel_q  <= '0;
			best_q <= mst_pkg::NoEdge;
			pick_q <= 1'b0;
			klbl_q <= '0;
		end else begin
			if (cmd.cnt_clr) begin
				j_q    <= '0;
				best_q <= mst_pkg::NoEdge;
				pick_q <= 1'b0;
			end else begin
				if (cmd.cnt_inc) begin
					j_q <= j_q + mst_pkg::CntW'(1);
				end
				if (cmd.sel_step && lc_rd != '0 && lc_rd < best_q) begin
					best_q <= lc_rd;
					sel_q  <= j_q[mst_pkg::IdxW-1:0];
					pick_q <= 1'b1;
				end
			end
			if (cmd.k_load) begin
				k_q <= j_q[mst_pkg::IdxW-1:0];
				e_q <= '0;
			end else if (cmd.join_en) begin
				k_q    <= sel_q;
				klbl_q <= lbl_rd;
				e_q    <= e_q + mst_pkg::IdxW'(1);
			end
		end
	end

	// Output register; a new result may load in the cycle the old one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q <= 1'b0;
		end else if (cmd.out_ld) begin
			o_vld_q <= 1'b1;
		end else if (!out_stall) begin
			o_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			o_status_q <= cmd.out_status;
			o_last_q   <= cmd.out_last;
			case (cmd.out_status)
				mst_pkg::ST_EDGE: begin
					o_from_q <= nl_q[sel_q];
					o_to_q   <= lbl_rd;
				end
				mst_pkg::ST_SINGLE: begin
					o_from_q <= val_q;
					o_to_q   <= val_q;
				end
				default: begin
					o_from_q <= '0;
					o_to_q   <= '0;
				end
			endcase
		end
	end

	assign o_valid  = o_vld_q;
	assign o_status = o_status_q;
	assign o_from   = o_from_q;
	assign o_to     = o_to_q;
	assign o_last   = o_last_q;

	always_comb begin
		sts.op        = op_q;
		sts.w_ok      = (val_q != '0) && !val_q[mst_pkg::DataW-1];
		sts.j_end     = (j_q == n_act);
		sts.lbl_match = (lbl_rd == val_q);
		sts.pick      = pick_q;
		sts.is_last   = ({1'b0, e_q} == (n_act - mst_pkg::CntW'(2)));
		sts.single    = (n_act == mst_pkg::CntW'(1));
		sts.out_free  = !o_vld_q || !out_stall;
	end

endmodule

>>> rtl/mst_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the spanning tree core.
// Sequences item decode, label search, cost scans and result emission; uses mst_pkg.
module mst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  mst_pkg::sts_t  sts,
	output mst_pkg::cmd_t  cmd
);

	mst_pkg::state_t state_q;
	mst_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mst_pkg::S_IDLE: begin
				if (in_valid) state_d = mst_pkg::S_DISPATCH;
			end
			mst_pkg::S_DISPATCH: begin
				case (sts.op)
					mst_pkg::OP_EDGE: state_d = sts.w_ok ? mst_pkg::S_EDGE_BA : mst_pkg::S_IDLE;
					mst_pkg::OP_RUN:  state_d = mst_pkg::S_FIND;
					default:          state_d = mst_pkg::S_IDLE;
				endcase
			end
			mst_pkg::S_EDGE_BA: state_d = mst_pkg::S_IDLE;
			mst_pkg::S_FIND: begin
				if (sts.j_end) begin
					state_d = mst_pkg::S_NOT_FOUND;
				end else if (sts.lbl_match) begin
					state_d = sts.single ? mst_pkg::S_SINGLE : mst_pkg::S_INIT;
				end
			end
			mst_pkg::S_NOT_FOUND, mst_pkg::S_SINGLE: begin
				if (sts.out_free) state_d = mst_pkg::S_IDLE;
			end
			mst_pkg::S_INIT, mst_pkg::S_UPDATE: begin
				if (sts.j_end) state_d = mst_pkg::S_SELECT;
			end
			mst_pkg::S_SELECT: begin
				if (sts.j_end) state_d = mst_pkg::S_EMIT;
			end
			mst_pkg::S_EMIT: begin
				if (sts.out_free) begin
					state_d = (!sts.pick || sts.is_last) ? mst_pkg::S_IDLE : mst_pkg::S_UPDATE;
				end
			end
			default: state_d = mst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.out_status = mst_pkg::ST_EDGE;
		in_stall       = (state_q != mst_pkg::S_IDLE);
		case (state_q)
			mst_pkg::S_IDLE: begin
				cmd.capture = in_valid;
			end
			mst_pkg::S_DISPATCH: begin
				case (sts.op)
					mst_pkg::OP_CLEAR: cmd.clear   = 1'b1;
					mst_pkg::OP_LABEL: cmd.lbl_wr  = 1'b1;
					mst_pkg::OP_EDGE:  cmd.ew_wr   = sts.w_ok;
					mst_pkg::OP_RUN:   cmd.cnt_clr = 1'b1;
					default:           cmd.cnt_clr = 1'b0;
				endcase
			end
			mst_pkg::S_EDGE_BA: begin
				cmd.ew_wr   = 1'b1;
				cmd.ew_swap = 1'b1;
			end
			mst_pkg::S_FIND: begin
				if (!sts.j_end) begin
					if (sts.lbl_match) begin
						cmd.k_load  = 1'b1;
						cmd.cnt_clr = 1'b1;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			mst_pkg::S_NOT_FOUND: begin
				cmd.out_ld     = sts.out_free;
				cmd.out_status = mst_pkg::ST_NOT_FOUND;
				cmd.out_last   = 1'b1;
			end
			mst_pkg::S_SINGLE: begin
				cmd.out_ld     = sts.out_free;
				cmd.out_status = mst_pkg::ST_SINGLE;
				cmd.out_last   = 1'b1;
			end
			mst_pkg::S_INIT, mst_pkg::S_UPDATE: begin
				cmd.upd_mode = (state_q == mst_pkg::S_UPDATE);
				if (sts.j_end) begin
					cmd.cnt_clr = 1'b1;
				end else begin
					cmd.rd_en   = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			mst_pkg::S_SELECT: begin
				if (!sts.j_end) begin
					cmd.sel_step = 1'b1;
					cmd.cnt_inc  = 1'b1;
				end
			end
			mst_pkg::S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					if (!sts.pick) begin
						cmd.out_status = mst_pkg::ST_DISCONNECTED;
						cmd.out_last   = 1'b1;
					end else begin
						cmd.out_status = mst_pkg::ST_EDGE;
						cmd.out_last   = sts.is_last;
						cmd.join_en    = 1'b1;
						cmd.cnt_clr    = !sts.is_last;
					end
				end
			end
			default: begin
				cmd.capture = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/mst_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Prim spanning tree core, bound to the top level.
// Depends on mst_pkg for the status codes.
module mst_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         in_valid,
	input logic         in_stall,
	input logic         out_valid,
	input logic         out_stall,
	input logic [1:0]   status,
	input logic [31:0]  from_label,
	input logic [31:0]  to_label,
	input logic         last
);

	// A held result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(from_label)
			&& $stable(to_label) && $stable(last))
		else $error("result beat changed while stalled");

	// The core works on one item at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in work");

	// Every special result closes its run.
	a_special_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != mst_pkg::ST_EDGE) |-> last)
		else $error("special result without last");

	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mst_pkg::ST_NOT_FOUND || status == mst_pkg::ST_DISCONNECTED)
			|-> from_label == '0 && to_label == '0)
		else $error("special result carries labels");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == mst_pkg::ST_SINGLE) |-> from_label == to_label)
		else $error("single vertex result with differing labels");

endmodule

bind prim_minimum_spanning_tree_core mst_checker u_mst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.status     (status),
	.from_label (from_label),
	.to_label   (to_label),
	.last       (last)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for prim_minimum_spanning_tree_core: a directed table,
// then random graph builds and runs, checked against a Prim predictor or, for typed rows, the table's beat.
// Depends on mst_pkg and the core RTL.
module testbench;
	import mst_pkg::*;

	localparam int CycleLimit = 2000000;
	localparam int SettleCycles = 60;

	typedef struct {
		status_t     st;
		logic [31:0] from_lbl;
		logic [31:0] to_lbl;
		logic        last;
	} tree_beat_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_ITEM,
		ROW_TYPED
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		opcode_t     op;
		logic [3:0]  a;
		logic [3:0]  b;
		logic [31:0] v;
		status_t     ex_st;
		logic [31:0] ex_from;
		logic [31:0] ex_to;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [4:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] opcode;
	logic [3:0] index_a;
	logic [3:0] index_b;
	logic signed [31:0] value;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic signed [31:0] from_label;
	logic signed [31:0] to_label;
	logic last;

	// Graph as the predictor sees it.
	logic [WeightW-1:0] graph_weight [MaxVertices][MaxVertices];
	logic [31:0] graph_label [MaxVertices];
	logic [WeightW-1:0] reach_cost [MaxVertices];
	logic [31:0] reach_from [MaxVertices];
	logic [4:0] vertex_reg;

	tree_beat_t tree_edges_due[$];
	int errors;
	int cycles;
	int sent;
	bit quiet;
	bit calm;
	int stall_left;

	prim_minimum_spanning_tree_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.index_a    (index_a),
		.index_b    (index_b),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.from_label (from_label),
		.to_label   (to_label),
		.last       (last)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic int active_vertices();
		int n;
		n = vertex_reg;
		if (n < 1) n = 1;
		if (n > MaxVertices) n = MaxVertices;
		return n;
	endfunction

	task automatic prim_tree(input logic [31:0] start, ref tree_beat_t res[$]);
		int n;
		int k;
		int i;
		int j;
		bit found;
		bit pick;
		bit stop;
		logic [WeightW-1:0] best;
		n = active_vertices();
		k = 0;
		found = 0;
		stop = 0;
		for (i = 0; i < n; i++) begin
			if (!found && graph_label[i] == start) begin
				k = i;
				found = 1;
			end
		end
		if (!found) begin
			res.push_back('{ST_NOT_FOUND, 32'd0, 32'd0, 1'b1});
		end else if (n == 1) begin
			res.push_back('{ST_SINGLE, start, start, 1'b1});
		end else begin
			for (i = 0; i < n; i++) begin
				reach_from[i] = start;
				reach_cost[i] = graph_weight[k][i];
			end
			reach_cost[k] = '0;
			for (i = 1; i < n && !stop; i++) begin
				best = NoEdge;
				pick = 0;
				for (j = 0; j < n; j++) begin
					if (reach_cost[j] != 0 && reach_cost[j] < best) begin
						best = reach_cost[j];
						k = j;
						pick = 1;
					end
				end
				if (!pick) begin
					res.push_back('{ST_DISCONNECTED, 32'd0, 32'd0, 1'b1});
					stop = 1;
				end else begin
					res.push_back('{ST_EDGE, reach_from[k], graph_label[k], i == n - 1});
					reach_cost[k] = '0;
					for (j = 0; j < n; j++) begin
						if (graph_weight[k][j] < reach_cost[j]) begin
							reach_from[j] = graph_label[k];
							reach_cost[j] = graph_weight[k][j];
						end
					end
				end
			end
		end
	endtask

	task automatic apply_item(input opcode_t op, input logic [3:0] a, input logic [3:0] b,
			input logic [31:0] v, ref tree_beat_t res[$]);
		case (op)
			OP_CLEAR: begin
				for (int i = 0; i < MaxVertices; i++)
					for (int j = 0; j < MaxVertices; j++)
						graph_weight[i][j] = NoEdge;
			end
			OP_LABEL: begin
				graph_label[a] = v;
			end
			OP_EDGE: begin
				if (v != 0 && !v[31]) begin
					graph_weight[a][b] = v[WeightW-1:0];
					graph_weight[b][a] = v[WeightW-1:0];
				end
			end
			default: begin
				prim_tree(v, res);
			end
		endcase
	endtask

	// Drives one item, waits until it is taken, then maybe idles the sender for a burst.
	task automatic send_item(input opcode_t op, input logic [3:0] a, input logic [3:0] b,
			input logic [31:0] v, input bit typed, input tree_beat_t typed_beat);
		tree_beat_t res[$];
		int gap;
		in_valid <= 1'b1;
		opcode <= op;
		index_a <= a;
		index_b <= b;
		value <= v;
		do @(posedge clk); while (in_stall);
		apply_item(op, a, b, v, res);
		if (typed)
			tree_edges_due.push_back(typed_beat);
		else
			foreach (res[i]) tree_edges_due.push_back(res[i]);
		sent++;
		if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_vertex_count(input logic [4:0] cnt);
		in_valid <= 1'b0;
		wait (tree_edges_due.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cnt;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		vertex_reg = cnt;
	endtask

	task automatic send_plain(input opcode_t op, input logic [3:0] a, input logic [3:0] b,
			input logic [31:0] v);
		send_item(op, a, b, v, 0, '{ST_EDGE, 32'd0, 32'd0, 1'b0});
	endtask

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(1, 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		tree_beat_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (tree_edges_due.size() == 0) begin
				$display("%0t: result beat with none expected: status %0d from %0d to %0d",
					$time, status, from_label, to_label);
				errors++;
			end else begin
				due = tree_edges_due.pop_front();
				if (status !== due.st) begin
					$display("%0t: status expected %0d actual %0d", $time, due.st, status);
					errors++;
				end
				if (from_label !== due.from_lbl) begin
					$display("%0t: from_label expected %0d actual %0d", $time,
						$signed(due.from_lbl), from_label);
					errors++;
				end
				if (to_label !== due.to_lbl) begin
					$display("%0t: to_label expected %0d actual %0d", $time,
						$signed(due.to_lbl), to_label);
					errors++;
				end
				if (last !== due.last) begin
					$display("%0t: last expected %0d actual %0d", $time, due.last, last);
					errors++;
				end
			end
		end
	end

	stim_row_t directed [] = '{
		'{ROW_CFG,   OP_CLEAR, 4'd0,  4'd0,  32'd4,         ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_LABEL, 4'd0,  4'd0,  32'h8000_0000, ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_LABEL, 4'd1,  4'd0,  32'h7fff_ffff, ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_LABEL, 4'd2,  4'd0,  32'd5,         ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_LABEL, 4'd3,  4'd0,  32'd5,         ST_EDGE, 0, 0},
		'{ROW_TYPED, OP_RUN,   4'd0,  4'd0,  32'd1234,      ST_NOT_FOUND, 0, 0},
		'{ROW_TYPED, OP_RUN,   4'd15, 4'd15, 32'd5,         ST_DISCONNECTED, 0, 0},
		'{ROW_ITEM,  OP_EDGE,  4'd0,  4'd1,  32'd0,         ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_EDGE,  4'd0,  4'd1,  32'hffff_ffff, ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_EDGE,  4'd0,  4'd2,  32'd1,         ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_EDGE,  4'd2,  4'd3,  32'h7fff_fffe, ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_EDGE,  4'd1,  4'd3,  32'd3,         ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_EDGE,  4'd1,  4'd0,  32'd3,         ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_EDGE,  4'd15, 4'd15, 32'd9,         ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_RUN,   4'd0,  4'd0,  32'h7fff_ffff, ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_RUN,   4'd0,  4'd0,  32'd5,         ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_EDGE,  4'd3,  4'd1,  32'h7fff_ffff, ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_RUN,   4'd0,  4'd0,  32'h8000_0000, ST_EDGE, 0, 0},
		'{ROW_ITEM,  OP_CLEAR, 4'd15, 4'd15, 32'hffff_ffff, ST_EDGE, 0, 0},
		'{ROW_TYPED, OP_RUN,   4'd0,  4'd0,  32'd5,         ST_DISCONNECTED, 0, 0},
		'{ROW_CFG,   OP_CLEAR, 4'd0,  4'd0,  32'd1,         ST_EDGE, 0, 0},
		'{ROW_TYPED, OP_RUN,   4'd0,  4'd0,  32'h8000_0000, ST_SINGLE,
			32'h8000_0000, 32'h8000_0000},
		'{ROW_TYPED, OP_RUN,   4'd0,  4'd0,  32'd7,         ST_NOT_FOUND, 0, 0},
		'{ROW_ITEM,  OP_LABEL, 4'd15, 4'd0,  32'd0,         ST_EDGE, 0, 0}
	};

	int phase_counts [] = '{16, 0, 31, 2, 17, 5, 16, 3, 9, 1, 16, 12};

	function automatic logic [31:0] random_label();
		return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 12);
	endfunction

	function automatic logic [31:0] random_weight();
		case ($urandom_range(0, 5))
			0: return $urandom & 32'h7fff_ffff;
			1: return 32'h7fff_fffe;
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	initial begin
		int n;
		int r;
		int ph;
		logic [3:0] a;
		logic [3:0] b;
		bit waited;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = '0;
		index_a = '0;
		index_b = '0;
		value = '0;
		out_stall = 1'b0;
		errors = 0;
		cycles = 0;
		sent = 0;
		quiet = 0;
		calm = 0;
		stall_left = 0;
		vertex_reg = 5'd16;
		for (int i = 0; i < MaxVertices; i++)
			for (int j = 0; j < MaxVertices; j++)
				graph_weight[i][j] = NoEdge;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_vertex_count(directed[i].v[4:0]);
			else
				send_item(directed[i].op, directed[i].a, directed[i].b, directed[i].v,
					directed[i].kind == ROW_TYPED,
					'{directed[i].ex_st, directed[i].ex_from, directed[i].ex_to, 1'b1});
		end

		// Labels for all vertices first, so no run ever reads one never loaded.
		write_vertex_count(5'd16);
		for (int i = 0; i < MaxVertices; i++)
			send_plain(OP_LABEL, i[3:0], 4'($urandom), random_label());

		ph = 0;
		waited = 0;
		while (sent < 530) begin
			write_vertex_count(ph < phase_counts.size() ? 5'(phase_counts[ph]) : 5'($urandom));
			ph++;
			calm = ($urandom_range(0, 3) == 0);
			n = active_vertices();
			for (int s = 0; s < 45 && sent < 530; s++) begin
				quiet = (sent >= 470);
				if (quiet) calm = 0;
				r = $urandom_range(0, 99);
				a = 4'($urandom_range(0, n - 1));
				b = 4'($urandom_range(0, n - 1));
				if (r < 4) begin
					send_plain(OP_CLEAR, 4'($urandom), 4'($urandom), $urandom);
				end else if (r < 10) begin
					for (int i = 0; i + 1 < n; i++)
						send_plain(OP_EDGE, i[3:0], 4'(i + 1), random_weight());
				end else if (r < 18) begin
					send_plain(OP_LABEL, 4'($urandom), 4'($urandom), random_label());
				end else if (r < 58) begin
					send_plain(OP_EDGE, a, b, random_weight());
				end else if (r < 85) begin
					send_plain(OP_RUN, 4'($urandom), 4'($urandom), graph_label[a]);
				end else if (r < 92) begin
					send_plain(OP_RUN, 4'($urandom), 4'($urandom), $urandom);
				end else begin
					// Rejected or out-of-range edge writes.
					send_plain(OP_EDGE, 4'($urandom), 4'($urandom),
						$urandom_range(0, 1) ? ($urandom | 32'h8000_0000) :
						($urandom_range(0, 1) ? 32'd0 : 32'h7fff_ffff));
				end
				if (!waited && sent > 200 && tree_edges_due.size() != 0) begin
					in_valid <= 1'b0;
					wait (tree_edges_due.size() == 0);
					@(posedge clk);
					waited = 1;
				end
			end
		end
		in_valid <= 1'b0;
		wait (tree_edges_due.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
